### hdl/sia_pkg.sv
// Package: constants, types and the sequencer state type of the influence accumulator.
package sia_pkg;
    localparam int MaxSources = 16;
    localparam int SlotW      = $clog2(MaxSources);
    localparam int CntW       = $clog2(MaxSources + 1);
    localparam int RadW       = 18;
    localparam int PosW       = 32;
    localparam int AmtW       = 16;
    localparam int BrdW       = 13;
    localparam int LvlW       = 13;
    localparam int SqW        = 38;   // radius^2 < 2^36, sum of three squares fits
    localparam int RootW      = 31;   // isqrt(S * 2^24) < r * 2^12 < 2^30
    localparam int EntW       = 3 * PosW + RadW + AmtW + BrdW;

    localparam logic [1:0] RegBase   = 2'd0;
    localparam logic [1:0] RegActive = 2'd1;

    localparam logic signed [AmtW+1:0] LevelLimit = 18'sd16384;
    localparam logic [12:0]            OneQ12     = 13'd4096;

    typedef enum logic [3:0] {
        t_idle, t_read, t_diff, t_sq, t_sqadd, t_sqrt, t_div, t_fade, t_fdiv,
        t_acc, t_out
    } t_state;
endpackage

### hdl/sia_ram.sv
// Generic simple dual port RAM (one write port, one read port) with registered read.
module sia_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/spherical_influence_accumulate.sv
// Top level: source table, sequencer and shared iterative arithmetic unit.
// Spherical influence accumulator.
// Input channel (i_valid/o_ready): action 0 loads a source into a table slot,
// action 1 evaluates a point. Only evaluate items produce a result beat on the
// output channel (o_valid/i_ready) carrying level (Q1.12) and covered.
// Registers via APB: 0 base_level, 1 active_sources (clamped to the table size).
// A load is written straight into the table. An evaluate walks the active sources
// one at a time: per source table read, difference and square work, square root
// (one result bit a cycle plus set-up), radius division, one fade decision and,
// when the source fades, fade division, all from one shared shift/subtract unit.
// A source outside the radius skips the root and both divisions.
// The block is not ready while an item is in work. A result is held in the
// output register until taken; one further evaluate may be taken meanwhile and
// then waits with the block not ready, so a stalled receiver stalls the block.
// Reset (synchronous, active low) clears the APB registers, the result valid and the sequencer; the source
// table is not cleared and must be loaded before it is walked.
module spherical_influence_accumulate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_action,
    input  logic [sia_pkg::SlotW-1:0]      i_slot,
    input  logic signed [sia_pkg::PosW-1:0] i_pos_x,
    input  logic signed [sia_pkg::PosW-1:0] i_pos_y,
    input  logic signed [sia_pkg::PosW-1:0] i_pos_z,
    input  logic [sia_pkg::RadW-1:0]       i_radius,
    input  logic signed [sia_pkg::AmtW-1:0] i_amount,
    input  logic [sia_pkg::BrdW-1:0]       i_border,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [sia_pkg::LvlW-1:0]       o_level,
    output logic                           o_covered,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import sia_pkg::*;

    t_state r_state, n_state;

    logic signed [AmtW-1:0] r_base;
    logic [4:0]             r_active;
    logic                   cfg_we;

    logic signed [PosW-1:0] r_px, r_py, r_pz;
    logic [CntW-1:0]        r_k, n_k;
    logic [CntW-1:0]        lim;

    logic [EntW-1:0]        ent;
    logic signed [PosW-1:0] e_x, e_y, e_z;
    logic [RadW-1:0]        e_r;
    logic signed [AmtW-1:0] e_a;
    logic [BrdW-1:0]        e_b;

    // shared unit working registers
    logic [1:0]             r_sub;     // axis counter
    logic [PosW:0]          r_d0, r_d1, r_d2;
    logic [SqW-1:0]         r_s;
    logic [63:0]            r_x;       // sqrt remainder / division remainder
    logic [63:0]            r_res;
    logic [63:0]            r_bit;
    logic [5:0]             r_cnt;
    logic [31:0]            r_q;
    logic                   r_neg;
    logic signed [AmtW+1:0] r_sum;
    logic                   r_ovalid;
    logic [LvlW-1:0]        r_level;
    logic                   r_cov;

    logic                   in_acc, load_we;

    assign o_ready   = (r_state == t_idle);
    assign in_acc    = i_valid && o_ready;
    assign load_we   = in_acc && !i_action;
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign o_valid   = r_ovalid;
    assign o_level   = r_level;
    assign o_covered = r_cov;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            RegBase[0]:   prdata = {{(32-AmtW){r_base[AmtW-1]}}, r_base};
            RegActive[0]: prdata = {27'd0, r_active};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_active <= '0;
        end else if (cfg_we) begin
            if (paddr[2] == RegBase[0]) r_base <= pwdata[AmtW-1:0];
            else r_active <= pwdata[4:0];
        end
    end

    assign lim = (r_active > 5'(MaxSources)) ? CntW'(MaxSources) : CntW'(r_active);

    sia_ram #(.Width(EntW), .Depth(MaxSources)) u_tab (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_slot),
        .i_wdata ({i_pos_x, i_pos_y, i_pos_z, i_radius, i_amount, i_border}),
        .i_raddr (r_k[SlotW-1:0]),
        .o_rdata (ent)
    );
    assign {e_x, e_y, e_z, e_r, e_a, e_b} = ent;

    // absolute difference on the current axis
    logic signed [PosW:0] dsel;
    logic [PosW:0]        adiff;
    always_comb begin
        case (r_sub)
            2'd0:    dsel = {r_px[PosW-1], r_px} - {e_x[PosW-1], e_x};
            2'd1:    dsel = {r_py[PosW-1], r_py} - {e_y[PosW-1], e_y};
            default: dsel = {r_pz[PosW-1], r_pz} - {e_z[PosW-1], e_z};
        endcase
        adiff = dsel[PosW] ? (PosW+1)'(-dsel) : dsel;
    end

    // one square per cycle; diffs are < 2^18 once checked against radius
    logic [RadW-1:0] sq_in;
    logic [2*RadW-1:0] sq;
    always_comb begin
        case (r_sub)
            2'd0:    sq_in = r_d0[RadW-1:0];
            2'd1:    sq_in = r_d1[RadW-1:0];
            default: sq_in = r_d2[RadW-1:0];
        endcase
        sq = sq_in * sq_in;
    end

    logic [2*RadW-1:0] rsq;
    assign rsq = e_r * e_r;

    logic [63:0] trial;
    logic        sq_ge;
    assign trial = r_res + r_bit;
    assign sq_ge = r_x >= trial;

    // shared divider step: restoring, quotient bit per cycle
    logic [63:0] dshift;
    logic [12:0] fden;
    assign fden   = OneQ12 - e_b;
    assign dshift = {r_x[62:0], r_res[63]};

    logic [12:0] tval;
    assign tval = r_q[12:0];

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            t_idle: if (in_acc && i_action) n_state = t_read;
            t_read: begin
                if (r_k >= lim) n_state = t_out;
                else n_state = t_diff;
            end
            t_diff: if (r_sub == 2'd2) n_state = t_sq;
            t_sq: begin
                if (r_d0 >= (PosW+1)'(e_r) || r_d1 >= (PosW+1)'(e_r) ||
                    r_d2 >= (PosW+1)'(e_r)) begin
                    n_state = t_read;
                    n_k     = r_k + 1'b1;
                end else if (r_sub == 2'd2) n_state = t_sqadd;
            end
            t_sqadd: begin
                if (r_s >= SqW'(rsq)) begin
                    n_state = t_read;
                    n_k     = r_k + 1'b1;
                end else n_state = t_sqrt;
            end
            t_sqrt: if (r_bit == 64'd0) n_state = t_div;
            t_div: if (r_cnt == 6'd0) n_state = t_fade;
            t_fade: begin
                if (e_b < BrdW'(OneQ12) && tval > e_b) n_state = t_fdiv;
                else n_state = t_acc;
            end
            t_fdiv: if (r_cnt == 6'd0) n_state = t_acc;
            t_acc: begin
                n_state = t_read;
                n_k     = r_k + 1'b1;
            end
            t_out: if (!r_ovalid) n_state = t_idle;
            default: n_state = t_idle;
        endcase
        if (r_state == t_idle) n_k = '0;
    end

    logic signed [AmtW+2:0] addv, nsum;
    logic signed [AmtW+1:0] sat_sum, base_sat;
    always_comb begin
        addv = r_neg ? -$signed({3'b000, r_q[AmtW-1:0]}) : $signed({3'b000, r_q[AmtW-1:0]});
        nsum = {r_sum[AmtW+1], r_sum} + addv;
        if (nsum > (AmtW+3)'(LevelLimit)) sat_sum = LevelLimit;
        else if (nsum < -(AmtW+3)'(LevelLimit)) sat_sum = -LevelLimit;
        else sat_sum = nsum[AmtW+1:0];
        if ($signed({r_base[AmtW-1], r_base, 1'b0}) > $signed({LevelLimit, 1'b0}))
            base_sat = LevelLimit;
        else if ((AmtW+2)'(r_base) < -LevelLimit) base_sat = -LevelLimit;
        else base_sat = (AmtW+2)'(r_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_idle;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            else if (r_state == t_out && !r_ovalid) r_ovalid <= 1'b1;
        end
    end

    logic [AmtW-1:0] amag;
    assign amag = e_a[AmtW-1] ? AmtW'(-e_a) : AmtW'(e_a);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            t_idle: begin
                r_px  <= i_pos_x;
                r_py  <= i_pos_y;
                r_pz  <= i_pos_z;
                r_sum <= base_sat;
                r_sub <= 2'd0;
            end
            t_read: r_sub <= 2'd0;
            t_diff: begin
                case (r_sub)
                    2'd0:    r_d0 <= adiff;
                    2'd1:    r_d1 <= adiff;
                    default: r_d2 <= adiff;
                endcase
                r_sub <= (r_sub == 2'd2) ? 2'd0 : r_sub + 1'b1;
                r_s   <= '0;
            end
            t_sq: begin
                r_s   <= r_s + SqW'(sq);
                r_sub <= r_sub + 1'b1;
                r_x   <= 64'({r_s + SqW'(sq), 24'd0});
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            t_sqadd: ;
            t_sqrt: begin
                if (r_bit != 64'd0) begin
                    if (sq_ge) begin
                        r_x   <= r_x - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else r_res <= r_res >> 1;
                    r_bit <= r_bit >> 2;
                end else begin
                    // start division isqrt / radius: dividend in r_res, remainder r_x
                    r_res <= r_res << 33;
                    r_x   <= '0;
                    r_q   <= '0;
                    r_cnt <= 6'd30;
                end
            end
            t_div: begin
                if (dshift >= 64'(e_r)) begin
                    r_x <= dshift - 64'(e_r);
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_x <= dshift;
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_res <= r_res << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            t_fade: begin
                r_neg <= e_a[AmtW-1];
                r_q   <= {16'd0, amag};
                r_res <= 64'((amag * (AmtW+14)'(OneQ12 - tval))) << (64 - AmtW - 14);
                r_x   <= '0;
                r_cnt <= 6'(AmtW + 13);
            end
            t_fdiv: begin
                if (dshift >= 64'(fden)) begin
                    r_x <= dshift - 64'(fden);
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_x <= dshift;
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_res <= r_res << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            t_acc: r_sum <= sat_sum;
            t_out: begin
                if (!r_ovalid) begin
                    if (r_sum <= 0) begin
                        r_level <= '0;
                        r_cov   <= 1'b0;
                    end else begin
                        r_level <= (r_sum > (AmtW+2)'(OneQ12)) ? OneQ12 : r_sum[LvlW-1:0];
                        r_cov   <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end
endmodule

### verif/sia_checker.sv
// Checker: watches both channels and the register port, predicts levels, compares.
`timescale 1ns / 1ps
module sia_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_ready,
    input  logic                            i_action,
    input  logic [sia_pkg::SlotW-1:0]       i_slot,
    input  logic signed [sia_pkg::PosW-1:0] i_pos_x,
    input  logic signed [sia_pkg::PosW-1:0] i_pos_y,
    input  logic signed [sia_pkg::PosW-1:0] i_pos_z,
    input  logic [sia_pkg::RadW-1:0]        i_radius,
    input  logic signed [sia_pkg::AmtW-1:0] i_amount,
    input  logic [sia_pkg::BrdW-1:0]        i_border,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic [sia_pkg::LvlW-1:0]        o_level,
    input  logic                            o_covered,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_results
);
    import sia_pkg::*;

    typedef struct {
        logic [LvlW-1:0] level;
        logic            covered;
    } t_level;

    localparam longint LevelSat = 16384;
    localparam longint OneQ12L  = 4096;

    longint             ctr_x [MaxSources];
    longint             ctr_y [MaxSources];
    longint             ctr_z [MaxSources];
    longint             src_rad [MaxSources];
    longint             src_amt [MaxSources];
    longint             src_brd [MaxSources];
    logic signed [15:0] base_reg;
    logic [4:0]         active_reg;
    t_level             level_q[$];
    int                 mismatches;

    assign o_pending    = level_q.size();
    assign o_fail_count = mismatches;

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > x) bt >>= 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint clip_level(longint v);
        if (v > LevelSat) return LevelSat;
        if (v < -LevelSat) return -LevelSat;
        return v;
    endfunction

    function automatic longint absdiff(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_level influence_at(longint px, longint py, longint pz);
        t_level res;
        int     n;
        longint acc, ax, ay, az, r, sq, t, add;
        n   = (active_reg > MaxSources) ? MaxSources : int'(active_reg);
        acc = clip_level(longint'(base_reg));
        for (int k = 0; k < n; k++) begin
            r  = src_rad[k];
            ax = absdiff(px, ctr_x[k]);
            ay = absdiff(py, ctr_y[k]);
            az = absdiff(pz, ctr_z[k]);
            if (ax >= r || ay >= r || az >= r) continue;
            sq = ax * ax + ay * ay + az * az;
            if (sq >= r * r) continue;
            t   = longint'(root64(longint'(unsigned'(sq)) << 24)) / r;
            add = src_amt[k];
            if (src_brd[k] < OneQ12L && t > src_brd[k])
                add = (add * (OneQ12L - t)) / (OneQ12L - src_brd[k]);
            acc = clip_level(acc + add);
        end
        if (acc <= 0) begin
            res.level   = '0;
            res.covered = 1'b0;
        end else begin
            res.level   = (acc > OneQ12L) ? LvlW'(OneQ12L) : LvlW'(acc);
            res.covered = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_level want;
        if (!i_rst_n) begin
            base_reg   <= '0;
            active_reg <= '0;
            level_q.delete();
            mismatches = 0;
            o_results  = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2:2] == RegBase[0:0])
                    base_reg <= pwdata[15:0];
                else if (paddr[2:2] == RegActive[0:0])
                    active_reg <= pwdata[4:0];
            end
            if (o_valid && i_ready) begin
                o_results++;
                if (level_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: level %0d covered %0d",
                                 o_level, o_covered);
                end else begin
                    want = level_q.pop_front();
                    if (want.level !== o_level || want.covered !== o_covered) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: level exp %0d got %0d, covered exp %0d got %0d",
                                     want.level, o_level, want.covered, o_covered);
                    end
                end
            end
            if (i_valid && o_ready) begin
                if (i_action == 1'b0) begin
                    ctr_x[i_slot]   = longint'(i_pos_x);
                    ctr_y[i_slot]   = longint'(i_pos_y);
                    ctr_z[i_slot]   = longint'(i_pos_z);
                    src_rad[i_slot] = longint'(i_radius);
                    src_amt[i_slot] = longint'(i_amount);
                    src_brd[i_slot] = longint'(i_border);
                end else begin
                    level_q = {level_q, influence_at(longint'(i_pos_x), longint'(i_pos_y),
                                                     longint'(i_pos_z))};
                end
            end
        end
    end
endmodule

### verif/testbench.sv
// Testbench top: stimulus, register writes, idling and the verdict.
`timescale 1ns / 1ps
module testbench;
    import sia_pkg::*;

    typedef struct {
        logic                   action;
        logic [SlotW-1:0]       slot;
        logic signed [PosW-1:0] px, py, pz;
        logic [RadW-1:0]        radius;
        logic signed [AmtW-1:0] amount;
        logic [BrdW-1:0]        border;
    } t_beat;

    localparam logic ActLoad = 1'b0;
    localparam logic ActEval = 1'b1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   i_action = 1'b0;
    logic [SlotW-1:0]       i_slot = '0;
    logic signed [PosW-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [RadW-1:0]        i_radius = '0;
    logic signed [AmtW-1:0] i_amount = '0;
    logic [BrdW-1:0]        i_border = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [LvlW-1:0]        o_level;
    logic                   o_covered;
    logic                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    int                     fail_count, pending, results;

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    bit     hold_off       = 1'b0;
    int     n_loads = 0, n_evals = 0;
    longint shadow_x [MaxSources];
    longint shadow_y [MaxSources];
    longint shadow_z [MaxSources];
    longint shadow_r [MaxSources];

    always #4 i_clk = ~i_clk;

    spherical_influence_accumulate u_top (.*);

    sia_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_action, .i_slot, .i_pos_x, .i_pos_y,
        .i_pos_z, .i_radius, .i_amount, .i_border, .o_valid, .i_ready, .o_level,
        .o_covered, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    always @(negedge i_clk) begin
        if (hold_off)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // called at a falling edge; returns at the falling edge after the beat is taken,
    // valid left high so the next beat can follow directly
    task automatic send_beat(t_beat b);
        bit rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= b.action;
        i_slot   <= b.slot;
        i_pos_x  <= b.px;
        i_pos_y  <= b.py;
        i_pos_z  <= b.pz;
        i_radius <= b.radius;
        i_amount <= b.amount;
        i_border <= b.border;
        do begin
            @(posedge i_clk);
            rdy = o_ready;
            @(negedge i_clk);
        end while (!rdy);
        if (b.action == ActLoad) begin
            shadow_x[b.slot] = b.px;
            shadow_y[b.slot] = b.py;
            shadow_z[b.slot] = b.pz;
            shadow_r[b.slot] = b.radius;
            n_loads++;
        end else begin
            n_evals++;
        end
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx[0], 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_beat load_beat(int slot, longint x, longint y, longint z,
                                        int rad, int amt, int brd);
        t_beat b;
        b.action = ActLoad;
        b.slot   = SlotW'(slot);
        b.px     = PosW'(x);
        b.py     = PosW'(y);
        b.pz     = PosW'(z);
        b.radius = RadW'(rad);
        b.amount = AmtW'(amt);
        b.border = BrdW'(brd);
        return b;
    endfunction

    function automatic t_beat eval_beat(longint x, longint y, longint z);
        t_beat b;
        b        = load_beat(0, x, y, z, $urandom, $urandom, $urandom);
        b.action = ActEval;
        b.slot   = SlotW'($urandom);
        return b;
    endfunction

    function automatic longint offset_in(longint r);
        longint h;
        h = (r > 2) ? r / 2 : 1;
        return longint'($urandom_range(0, 2 * h)) - h;
    endfunction

    function automatic t_beat random_beat();
        int     k, rad;
        longint cx, cy, cz;
        if ($urandom_range(99) < 35) begin
            // mostly a cluster so sources overlap, now and then anywhere
            if ($urandom_range(9) == 0) begin
                cx = longint'(signed'($urandom)); cy = longint'(signed'($urandom));
                cz = longint'(signed'($urandom));
            end else begin
                cx = $urandom_range(0, 8000) - 4000; cy = $urandom_range(0, 8000) - 4000;
                cz = $urandom_range(0, 8000) - 4000;
            end
            case ($urandom_range(3))
                0:       rad = $urandom_range(0, 262143);
                1:       rad = $urandom_range(1, 64);
                default: rad = $urandom_range(500, 9000);
            endcase
            return load_beat($urandom_range(0, 15), cx, cy, cz, rad,
                             ($urandom_range(3) == 0) ? int'($urandom)
                                                      : $urandom_range(0, 32768) - 16384,
                             ($urandom_range(3) == 0) ? int'($urandom)
                                                      : $urandom_range(0, 4096));
        end
        if ($urandom_range(9) == 0)
            return eval_beat(longint'(signed'($urandom)), longint'(signed'($urandom)),
                             longint'(signed'($urandom)));
        k = $urandom_range(0, 15);
        return eval_beat(shadow_x[k] + offset_in(shadow_r[k]),
                         shadow_y[k] + offset_in(shadow_r[k]),
                         shadow_z[k] + offset_in(shadow_r[k]));
    endfunction

    initial begin
        int base_set [8]   = '{0, -32768, 32767, 4096, -4096, 16384, -16384, 1000};
        int active_set [8] = '{16, 3, 0, 5, 31, 1, 17, 4};
        int count;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every slot loaded first: the table has no reset value
        send_beat(load_beat(0, 0, 0, 0, 4096, 4096, 4096));
        send_beat(load_beat(1, 0, 0, 0, 0, 16384, 0));
        send_beat(load_beat(2, 100, -100, 50, 2048, -32768, 0));
        send_beat(load_beat(3, 0, 0, 0, 262143, 32767, 8191));
        send_beat(load_beat(4, -2147483648, -2147483648, -2147483648, 262143, -16384, 2048));
        send_beat(load_beat(5, 2147483647, 2147483647, 2147483647, 1, 16384, 4095));
        for (int s = 6; s < 16; s++)
            send_beat(load_beat(s, s * 300, -s * 200, s * 10, 1000 + s * 500,
                                s * 1500 - 12000, s * 256));
        i_valid <= 1'b0;
        reg_write(RegBase, 32'h0000_0800);
        reg_write(RegActive, 32'd16);
        send_beat(eval_beat(0, 0, 0));
        send_beat(eval_beat(100, -100, 50));
        send_beat(eval_beat(2000, 0, 0));
        send_beat(eval_beat(-2147483648, -2147483648, -2147483648));
        send_beat(eval_beat(2147483647, 2147483647, 2147483647));
        send_beat(eval_beat(2147483647, -2147483648, 0));
        send_beat(eval_beat(4095, 0, 0));
        send_beat(eval_beat(262142, 0, 0));
        i_valid <= 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            reg_write(RegBase, base_set[ph]);
            reg_write(RegActive, active_set[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            count = (active_set[ph] >= 16) ? 180 : 280;
            fork
                if (ph == 1) begin
                    // long receiver hold-off so the block backs up onto its input
                    repeat (50) @(negedge i_clk);
                    hold_off = 1'b1;
                    repeat (3000) @(negedge i_clk);
                    hold_off = 1'b0;
                end
                begin
                    for (int n = 0; n < count; n++)
                        send_beat(random_beat());
                    i_valid <= 1'b0;
                end
            join
        end

        wait (pending == 0);
        repeat (1600) @(posedge i_clk);
        $display("%0d loads and %0d evaluates over eight register settings,", n_loads, n_evals);
        $display("%0d result beats checked under varied idling and backpressure", results);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### filelist.f
hdl/sia_pkg.sv
hdl/sia_ram.sv
hdl/spherical_influence_accumulate.sv
verif/sia_checker.sv
verif/testbench.sv
